/* rtl/core/lsr_pkg.sv */
// Shared types and fixed widths for the line span rasterizer.
// Used by the divider, the top level and the bench, and for the channel payload types.
package lsr_pkg;

   localparam int X_W      = 7;   // column width
   localparam int Y_W      = 6;   // row width
   localparam int COLOUR_W = 15;  // 5-5-5 RGB
   localparam int ERR_W    = 10;  // signed error term, spans about -62..189
   localparam int RUN_W    = 8;   // dividend and quotient width of the run divider

   localparam logic [COLOUR_W-1:0] COLOUR_RESET = 15'h7FFF;

   typedef logic [COLOUR_W-1:0] colour_type;

   typedef struct packed {
      logic [X_W-1:0] x_start;
      logic [Y_W-1:0] y_start;
      logic [X_W-1:0] x_end;
      logic [Y_W-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic [Y_W-1:0]      row;
      logic [X_W-1:0]      span_left;
      logic [X_W-1:0]      span_right;
      logic [COLOUR_W-1:0] colour;
      logic                last;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/core/lsr_chan_if.sv */
// Valid/ready channel carrying one payload per transfer.
// Payload type comes from lsr_pkg at the instantiation site.
interface lsr_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/lsr_div.sv */
// Restoring divider for run lengths, one quotient bit per cycle.
// Depends on lsr_pkg for widths and the status struct.
module lsr_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [lsr_pkg::RUN_W-1:0]    dividend,
   input  logic [lsr_pkg::Y_W-1:0]      divisor,
   output logic [lsr_pkg::RUN_W-1:0]    quotient,
   output logic [lsr_pkg::Y_W-1:0]      remainder,
   output lsr_pkg::div_status_type      status
);
   localparam int CNT_W = $clog2(lsr_pkg::RUN_W + 1);

   logic [lsr_pkg::RUN_W-1:0] quo_ff, quo_in;
   logic [lsr_pkg::Y_W-1:0]   rem_ff, rem_in;
   logic [lsr_pkg::Y_W-1:0]   dvs_ff, dvs_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      done_ff, done_in;
   logic [lsr_pkg::Y_W:0]     trial;
   logic                      fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[lsr_pkg::RUN_W-1]};
      fits   = (trial >= {1'b0, dvs_ff});
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
         cnt_in = CNT_W'(lsr_pkg::RUN_W);
      end else if (cnt_ff != '0) begin
         // shift in one dividend bit, subtract when it fits
         rem_in  = fits ? lsr_pkg::Y_W'(trial - {1'b0, dvs_ff}) : lsr_pkg::Y_W'(trial);
         quo_in  = {quo_ff[lsr_pkg::RUN_W-2:0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = (cnt_ff != '0);
   assign status.done = done_ff;

endmodule

/* rtl/core/line_span_rasterizer_unit.sv */
// Line span rasterizer top level: endpoint setup, row sequencer, colour register.
// Depends on lsr_pkg, lsr_chan_if and the run divider lsr_div.
//
// Channel   Dir  Payload                                       Transfer when
// req_chan  in   x_start, y_start, x_end, y_end                 valid & ready
// rsp_chan  out  row, span_left, span_right, colour, last       valid & ready
// csr_chan  in   line_colour (15 bits)                          valid & ready
//
// One segment at a time: req_chan.ready is high only while the sequencer is idle.
// Each scanline passes through decide, place and present states, and waits on the 8-step
// divider between decide and place when the row is a long run; rsp stalls hold it in the
// present state. The rsp register holds a span until taken.
// Synchronous active-high reset clears the sequencer and sets the colour to white.
// csr_chan is always ready; write it only while no segment is in flight.
module line_span_rasterizer_unit #(
   parameter int SCREEN_COLS = 128,
   parameter int SCREEN_ROWS = 64
) (
   input  logic         clock,
   input  logic         reset,
   lsr_chan_if.sink     req_chan,
   lsr_chan_if.source   rsp_chan,
   lsr_chan_if.sink     csr_chan
);
   localparam int X_W   = lsr_pkg::X_W;
   localparam int Y_W   = lsr_pkg::Y_W;
   localparam int ERR_W = lsr_pkg::ERR_W;
   localparam int RUN_W = lsr_pkg::RUN_W;

   // Saturation limits; the port widths already cap coordinates at their own maximum.
   localparam logic [X_W-1:0] COL_MAX =
      X_W'((SCREEN_COLS > (1 << X_W)) ? ((1 << X_W) - 1) : (SCREEN_COLS - 1));
   localparam logic [Y_W-1:0] ROW_MAX =
      Y_W'((SCREEN_ROWS > (1 << Y_W)) ? ((1 << Y_W) - 1) : (SCREEN_ROWS - 1));

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_DIV,
      ST_PLACE,
      ST_EMIT
   } state_type;

   state_type                state_ff, state_in;
   logic [X_W-1:0]           x1_ff, x1_in;
   logic [Y_W-1:0]           y_ff, y_in;
   logic [Y_W-1:0]           y2_ff, y2_in;
   logic [X_W-1:0]           dx_ff, dx_in;
   logic [Y_W-1:0]           dy_ff, dy_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;
   logic [X_W-1:0]           u_ff, u_in;
   logic                     right_ff, right_in;
   logic [X_W-1:0]           lo_ff, lo_in;
   logic [X_W-1:0]           hi_ff, hi_in;
   logic                     last_ff, last_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   lsr_pkg::rsp_type         rsp_ff, rsp_in;
   lsr_pkg::colour_type      colour_ff, colour_in;

   // endpoint setup
   logic [X_W-1:0]           xa, xb, sx1, sx2;
   logic [Y_W-1:0]           ya, yb, sy1, sy2;
   logic [X_W-1:0]           sdx;
   logic [Y_W-1:0]           sdy;

   // row decision
   logic signed [ERR_W-1:0]  dx_s, dy_s;
   logic                     div_start;
   logic [RUN_W-1:0]         div_dividend;
   logic [RUN_W-1:0]         div_quo;
   logic [Y_W-1:0]           div_rem;
   lsr_pkg::div_status_type  div_stat;
   logic [RUN_W:0]           run_hi, run_next;

   lsr_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (dy_ff),
      .quotient  (div_quo),
      .remainder (div_rem),
      .status    (div_stat)
   );

   // Saturate, then order endpoints by row.
   always_comb begin
      xa = (32'(req_chan.payload.x_start) >= SCREEN_COLS) ? COL_MAX : req_chan.payload.x_start;
      xb = (32'(req_chan.payload.x_end)   >= SCREEN_COLS) ? COL_MAX : req_chan.payload.x_end;
      ya = (32'(req_chan.payload.y_start) >= SCREEN_ROWS) ? ROW_MAX : req_chan.payload.y_start;
      yb = (32'(req_chan.payload.y_end)   >= SCREEN_ROWS) ? ROW_MAX : req_chan.payload.y_end;
      if (yb < ya) begin
         sx1 = xb; sy1 = yb; sx2 = xa; sy2 = ya;
      end else begin
         sx1 = xa; sy1 = ya; sx2 = xb; sy2 = yb;
      end
      sdx = (sx2 > sx1) ? (sx2 - sx1) : (sx1 - sx2);
      sdy = sy2 - sy1;
   end

   assign dx_s         = $signed(ERR_W'(dx_ff));
   assign dy_s         = $signed(ERR_W'(dy_ff));
   assign div_dividend = RUN_W'(err_ff - dy_s);
   assign run_hi       = (RUN_W+1)'(u_ff) + (RUN_W+1)'(div_quo);
   assign run_next     = run_hi + (RUN_W+1)'(1);

   always_comb begin
      state_in     = state_ff;
      x1_in        = x1_ff;
      y_in         = y_ff;
      y2_in        = y2_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      err_in       = err_ff;
      u_in         = u_ff;
      right_in     = right_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      colour_in    = colour_ff;
      div_start    = 1'b0;

      // hold the colour register except on a csr transfer
      if (csr_chan.valid) begin
         colour_in = csr_chan.payload;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               x1_in    = sx1;
               y_in     = sy1;
               y2_in    = sy2;
               dx_in    = sdx;
               dy_in    = sdy;
               u_in     = '0;
               right_in = (sx2 > sx1);
               // steep lines start half a row back, shallow ones one full run ahead
               err_in   = ({1'b0, sdx} > {2'b00, sdy}) ? $signed(ERR_W'(sdx))
                                                       : -$signed(ERR_W'(sdy >> 1));
               state_in = ST_ROW;
            end
         end

         ST_ROW: begin
            priority if (y_ff == y2_ff) begin
               // final row runs to the end column
               lo_in    = u_ff;
               hi_in    = dx_ff;
               last_in  = 1'b1;
               state_in = ST_PLACE;
            end else if (u_ff == dx_ff) begin
               lo_in    = dx_ff;
               hi_in    = dx_ff;
               last_in  = 1'b0;
               state_in = ST_PLACE;
            end else if (err_ff < dy_s) begin
               // short step: one pixel, advance x by at most one column
               lo_in   = u_ff;
               hi_in   = u_ff;
               last_in = 1'b0;
               if (err_ff > -dx_s) begin
                  u_in   = u_ff + X_W'(1);
                  err_in = err_ff + dx_s - dy_s;
               end else begin
                  err_in = err_ff + dx_s;
               end
               state_in = ST_PLACE;
            end else begin
               // long run: hand the run length to the divider
               lo_in     = u_ff;
               last_in   = 1'b0;
               div_start = 1'b1;
               state_in  = ST_DIV;
            end
         end

         ST_DIV: begin
            if (div_stat.done) begin
               // clamp the run's far edge and the next x at the end column
               hi_in    = (run_hi > (RUN_W+1)'(dx_ff)) ? dx_ff : X_W'(run_hi);
               u_in     = (run_next > (RUN_W+1)'(dx_ff)) ? dx_ff : X_W'(run_next);
               err_in   = $signed(ERR_W'(div_rem)) + dx_s;
               state_in = ST_PLACE;
            end
         end

         ST_PLACE: begin
            rsp_in.row    = y_ff;
            rsp_in.colour = colour_ff;
            rsp_in.last   = last_ff;
            if (right_ff) begin
               rsp_in.span_left  = x1_ff + lo_ff;
               rsp_in.span_right = x1_ff + hi_ff;
            end else begin
               rsp_in.span_left  = x1_ff - hi_ff;
               rsp_in.span_right = x1_ff - lo_ff;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_EMIT;
         end

         ST_EMIT: begin
            if (rsp_chan.ready) begin
               rsp_valid_in = 1'b0;
               if (last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  y_in     = y_ff + Y_W'(1);
                  state_in = ST_ROW;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         colour_ff    <= lsr_pkg::COLOUR_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         colour_ff    <= colour_in;
      end
      x1_ff    <= x1_in;
      y_ff     <= y_in;
      y2_ff    <= y2_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      err_ff   <= err_in;
      u_ff     <= u_in;
      right_ff <= right_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      last_ff  <= last_in;
      rsp_ff   <= rsp_in;
   end

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // no new segment while a span is still waiting
   a_no_accept_while_presenting: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("segment accepted while a span is pending");

   // spans never run backwards
   a_span_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.payload.span_left <= rsp_chan.payload.span_right))
      else $error("span left edge beyond right edge");

   // the final span frees the block for the next segment
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.payload.last) |=> req_chan.ready)
      else $error("block not ready after last span");

   // divider result arrives only while the sequencer waits for it
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIV))
      else $error("divider finished outside run wait");

   a_div_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DIV) && !div_stat.done) |-> div_stat.busy)
      else $error("sequencer waiting on an idle divider");

endmodule

/* bench/tb_line_span_rasterizer_unit.sv */
// Self-checking bench for line_span_rasterizer_unit: directed segments, then random ones,
// with spans checked against typed-in answers or a tracer; random stalls in most phases.
// Depends on lsr_pkg, lsr_chan_if and the unit under test.
module tb_line_span_rasterizer_unit;

   localparam int RESET_CYCLES = 12;
   localparam int TAIL_CYCLES  = 32;
   localparam int CYCLE_LIMIT  = 2_500_000;
   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS [PHASES] = '{100, 100, 60, 100, 65};

   // Directed row: one segment, plus a typed-in span where the answer is obvious
   // (single-span segments at the reset colour).
   typedef struct packed {
      logic [lsr_pkg::X_W-1:0] xs;
      logic [lsr_pkg::Y_W-1:0] ys;
      logic [lsr_pkg::X_W-1:0] xe;
      logic [lsr_pkg::Y_W-1:0] ye;
      logic                    typed;
      logic [lsr_pkg::Y_W-1:0] row;
      logic [lsr_pkg::X_W-1:0] span_l;
      logic [lsr_pkg::X_W-1:0] span_r;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      // single points and horizontal segments, answer typed in
      '{7'd0,   6'd0,  7'd0,   6'd0,  1'b1, 6'd0,  7'd0,   7'd0},
      '{7'd127, 6'd63, 7'd127, 6'd63, 1'b1, 6'd63, 7'd127, 7'd127},
      '{7'd0,   6'd0,  7'd127, 6'd0,  1'b1, 6'd0,  7'd0,   7'd127},
      '{7'd127, 6'd63, 7'd0,   6'd63, 1'b1, 6'd63, 7'd0,   7'd127},
      '{7'd90,  6'd17, 7'd5,   6'd17, 1'b1, 6'd17, 7'd5,   7'd90},
      '{7'd85,  6'd42, 7'd85,  6'd42, 1'b1, 6'd42, 7'd85,  7'd85},
      '{7'd42,  6'd21, 7'd85,  6'd21, 1'b1, 6'd21, 7'd42,  7'd85},
      // vertical, diagonal, steep, long runs and overshoot: traced
      '{7'd0,   6'd0,  7'd0,   6'd63, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd127, 6'd63, 7'd127, 6'd0,  1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd0,   6'd0,  7'd63,  6'd63, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd0,   6'd0,  7'd127, 6'd63, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd127, 6'd63, 7'd0,   6'd0,  1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd127, 6'd0,  7'd0,   6'd63, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd0,   6'd63, 7'd127, 6'd0,  1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd0,   6'd0,  7'd127, 6'd1,  1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd64,  6'd0,  7'd0,   6'd1,  1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd0,   6'd10, 7'd127, 6'd11, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd3,   6'd30, 7'd120, 6'd35, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd100, 6'd5,  7'd3,   6'd9,  1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd10,  6'd0,  7'd12,  6'd63, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd127, 6'd0,  7'd126, 6'd63, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd50,  6'd20, 7'd51,  6'd21, 1'b0, 6'd0,  7'd0,   7'd0},
      '{7'd85,  6'd42, 7'd42,  6'd21, 1'b0, 6'd0,  7'd0,   7'd0}
   };

   logic clock;
   logic reset;

   lsr_chan_if #(.payload_type(lsr_pkg::req_type))    req_chan ();
   lsr_chan_if #(.payload_type(lsr_pkg::rsp_type))    rsp_chan ();
   lsr_chan_if #(.payload_type(lsr_pkg::colour_type)) csr_chan ();

   line_span_rasterizer_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   lsr_pkg::colour_type line_colour_now;   // mirror of the colour register
   lsr_pkg::rsp_type    expected_spans[$];
   bit                  idle_on;
   int                  stall_left;
   int                  cycle_count;
   int                  mismatches;
   int                  segments_sent;
   int                  spans_seen;

   always #2 clock = ~clock;

   // Queue one expected span at the current colour.
   function automatic void push_span(input int row, input int span_l, input int span_r,
                                     input bit last);
      lsr_pkg::rsp_type s;
      s.row        = row[lsr_pkg::Y_W-1:0];
      s.span_left  = span_l[lsr_pkg::X_W-1:0];
      s.span_right = span_r[lsr_pkg::X_W-1:0];
      s.colour     = line_colour_now;
      s.last       = last;
      expected_spans.push_back(s);
   endfunction

   // Trace one segment into spans, upper row first. Coordinates always fit the
   // 128x64 screen at these widths, so no saturation is needed.
   function automatic void predict_spans(input lsr_pkg::req_type seg);
      int x1, y1, x2, y2, dx, dy, err, u, lo, hi, run, nu, y;
      bit rightward;
      if (seg.y_start == seg.y_end) begin
         if (seg.x_start < seg.x_end)
            push_span(seg.y_start, seg.x_start, seg.x_end, 1'b1);
         else
            push_span(seg.y_start, seg.x_end, seg.x_start, 1'b1);
         return;
      end
      if (seg.y_end < seg.y_start) begin
         x1 = seg.x_end;   y1 = seg.y_end;   x2 = seg.x_start; y2 = seg.y_start;
      end else begin
         x1 = seg.x_start; y1 = seg.y_start; x2 = seg.x_end;   y2 = seg.y_end;
      end
      if (x1 == x2) begin
         for (y = y1; y <= y2; y++)
            push_span(y, x1, x1, y == y2);
         return;
      end
      // walk the column offset u from x1 towards x2
      rightward = x2 > x1;
      dx  = rightward ? x2 - x1 : x1 - x2;
      dy  = y2 - y1;
      err = (dx > dy) ? dx : -(dy / 2);
      u   = 0;
      for (y = y1; y <= y2; y++) begin
         if (y == y2) begin
            lo = u;
            hi = dx;
         end else if (u == dx) begin
            lo = dx;
            hi = dx;
         end else if (err < dy) begin
            // short step: at most one column per row
            lo = u;
            hi = u;
            if (err > -dx) begin
               u++;
               err += dx - dy;
            end else begin
               err += dx;
            end
         end else begin
            // long run: divide out whole rows, clamp the far edge at the end column
            run = (err - dy) / dy;
            err -= dy * run;
            lo = u;
            if (err > -dx) begin
               hi = u + run;
               nu = hi + 1;
               err -= dy;
            end else begin
               hi = u + run + 1;
               nu = hi;
            end
            if (hi > dx)
               hi = dx;
            u = (nu > dx) ? dx : nu;
            err += dx;
         end
         if (rightward)
            push_span(y, x1 + lo, x1 + hi, y == y2);
         else
            push_span(y, x1 - hi, x1 - lo, y == y2);
      end
   endfunction

   // Offer one segment, hold it until the transfer, then queue its spans.
   task automatic drive_segment(input lsr_pkg::req_type seg, input bit typed,
                                input lsr_pkg::rsp_type typed_span);
      @(posedge clock);
      if (idle_on && $urandom_range(0, 2) == 0)
         repeat ($urandom_range(1, 6)) @(posedge clock);
      req_chan.payload <= seg;
      req_chan.valid   <= 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      req_chan.valid <= 1'b0;
      if (typed)
         expected_spans.push_back(typed_span);
      else
         predict_spans(seg);
      segments_sent++;
   endtask

   task automatic write_colour(input lsr_pkg::colour_type c);
      @(posedge clock);
      csr_chan.payload <= c;
      csr_chan.valid   <= 1'b1;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid  <= 1'b0;
      line_colour_now = c;
   endtask

   task automatic wait_drained();
      while (expected_spans.size() != 0)
         @(posedge clock);
   endtask

   // Result side: stall ready in random bursts while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         rsp_chan.ready <= 1'b0;
         stall_left = $urandom_range(1, 6) - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compare each span transfer with the oldest expectation.
   always @(posedge clock) begin : check_spans
      lsr_pkg::rsp_type got, want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = rsp_chan.payload;
         spans_seen++;
         if (expected_spans.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected span: row %0d left %0d right %0d colour %h last %0d",
                        got.row, got.span_left, got.span_right, got.colour, got.last);
         end else begin
            want = expected_spans.pop_front();
            if (got.row !== want.row || got.span_left !== want.span_left ||
                got.span_right !== want.span_right || got.colour !== want.colour ||
                got.last !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("span %0d mismatch", spans_seen);
                  $display("  expected row %0d left %0d right %0d colour %h last %0d",
                           want.row, want.span_left, want.span_right, want.colour,
                           want.last);
                  $display("  actual   row %0d left %0d right %0d colour %h last %0d",
                           got.row, got.span_left, got.span_right, got.colour, got.last);
               end
            end
         end
      end
   end

   // Watchdog: end the run if the stimulus never drains.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d spans still expected",
               cycle_count, expected_spans.size());
      $display("FAIL line_span_rasterizer_unit");
      $finish;
   end

   initial begin
      lsr_pkg::req_type    seg;
      lsr_pkg::rsp_type    typed_span;
      lsr_pkg::colour_type next_colour;
      int                  xa, ya, xb, yb, d, shape;

      clock           = 1'b0;
      reset           = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      line_colour_now  = lsr_pkg::COLOUR_RESET;
      idle_on          = 1'b1;
      stall_left       = 0;
      mismatches       = 0;
      segments_sent    = 0;
      spans_seen       = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset colour.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         seg.x_start = DIRECTED[i].xs;
         seg.y_start = DIRECTED[i].ys;
         seg.x_end   = DIRECTED[i].xe;
         seg.y_end   = DIRECTED[i].ye;
         typed_span  = '{DIRECTED[i].row, DIRECTED[i].span_l, DIRECTED[i].span_r,
                         lsr_pkg::COLOUR_RESET, 1'b1};
         drive_segment(seg, DIRECTED[i].typed, typed_span);
      end

      // Random phases, each at its own colour; the third and the last run without idling.
      typed_span = '0;
      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         case (p)
            0:       next_colour = '0;
            1:       next_colour = '1;
            4:       next_colour = 15'h2AAA;
            default: next_colour = lsr_pkg::colour_type'($urandom_range(0, 32767));
         endcase
         write_colour(next_colour);
         idle_on = (p != 2) && (p != PHASES - 1);
         for (int i = 0; i < PHASE_ITEMS[p]; i++) begin
            xa = $urandom_range(0, 127);
            ya = $urandom_range(0, 63);
            xb = $urandom_range(0, 127);
            yb = $urandom_range(0, 63);
            shape = $urandom_range(0, 9);
            case (shape)
               0, 1, 2, 3: begin   // short segments keep these items quick
                  d  = $urandom_range(0, 4);
                  yb = $urandom_range(0, 1) ? ya + d : ya - d;
               end
               4: yb = ya;         // horizontal
               5: xb = xa;         // vertical
               6: begin            // shallow: long runs through the divider
                  d  = $urandom_range(1, 3);
                  yb = $urandom_range(0, 1) ? ya + d : ya - d;
               end
               7: begin            // near-diagonal
                  d  = $urandom_range(1, 20);
                  yb = ya + d;
                  xb = $urandom_range(0, 1) ? xa + d + $urandom_range(0, 2)
                                            : xa - d - $urandom_range(0, 2);
               end
               default: ;          // anywhere on screen
            endcase
            if (yb < 0)   yb = 0;
            if (yb > 63)  yb = 63;
            if (xb < 0)   xb = 0;
            if (xb > 127) xb = 127;
            seg.x_start = xa[lsr_pkg::X_W-1:0];
            seg.y_start = ya[lsr_pkg::Y_W-1:0];
            seg.x_end   = xb[lsr_pkg::X_W-1:0];
            seg.y_end   = yb[lsr_pkg::Y_W-1:0];
            drive_segment(seg, 1'b0, typed_span);
         end
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d segments (%0d directed) over five colour settings, %0d spans checked",
               segments_sent, DIRECTED_ROWS, spans_seen);
      $display("%0d mismatches in %0d cycles", mismatches, cycle_count);
      if (mismatches == 0)
         $display("PASS line_span_rasterizer_unit");
      else
         $display("FAIL line_span_rasterizer_unit");
      $finish;
   end

endmodule
